// File: design/ipd_frame_payload_extractor_defines.svh
// ----------------------------------------------------------------------------
// IPD deframer assertion macros
// Concurrent assertion wrappers on clk / rst_n; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef IPD_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define IPD_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define IPD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ipd assertion failed");
// condition never seen at a clock edge outside reset
`define IPD_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ipd forbidden condition seen");
`else
`define IPD_ASSERT(lbl, prop)
`define IPD_ASSERT_NEVER(lbl, cond)
`endif
`endif

// File: design/ipd_pkg.sv
// ----------------------------------------------------------------------------
// IPD deframer package
// Header characters, hunt positions and small types of the frame deframer.
// ----------------------------------------------------------------------------
package ipd_pkg;

    // hunt position: 0..4 header index, GATHER_POS gathering length chars
    typedef logic [2:0] hunt_pos_t;
    typedef logic [2:0] char_cnt_t;
    typedef logic [7:0] byte_t;

    localparam hunt_pos_t GATHER_POS = 3'd5;

    localparam byte_t CHAR_PLUS  = 8'h2B;  // '+'
    localparam byte_t CHAR_I     = 8'h49;  // 'I'
    localparam byte_t CHAR_P     = 8'h50;  // 'P'
    localparam byte_t CHAR_D     = 8'h44;  // 'D'
    localparam byte_t CHAR_COMMA = 8'h2C;  // ','
    localparam byte_t CHAR_COLON = 8'h3A;  // ':'
    localparam byte_t CHAR_ZERO  = 8'h30;  // '0'
    localparam byte_t CHAR_NINE  = 8'h39;  // '9'

    // expected header character at a hunt position
    function automatic byte_t header_char(input hunt_pos_t pos);
        byte_t c;
        case (pos)
            3'd0:    c = CHAR_PLUS;
            3'd1:    c = CHAR_I;
            3'd2:    c = CHAR_P;
            3'd3:    c = CHAR_D;
            3'd4:    c = CHAR_COMMA;
            default: c = CHAR_COMMA;
        endcase
        return c;
    endfunction

endpackage

// File: design/ipd_frame_payload_extractor.sv
// ----------------------------------------------------------------------------
// IPD frame payload extractor: pulls payload out of "+IPD,<len>:<data>" frames.
// The result word is registered from the accepted byte; one byte per cycle while in_stall is low.
// in_stall only when the result register is full and out_stall is high.
// rst_n (async, low) clears hunt, length and payload count, result invalid.
// ----------------------------------------------------------------------------
`include "ipd_frame_payload_extractor_defines.svh"

module ipd_frame_payload_extractor
    import ipd_pkg::*;
#(
    parameter int LENGTH_CHARS_MAX = 6,
    parameter int LENGTH_WIDTH     = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       passthrough,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] data_byte,
    output logic       last_of_payload
);

    typedef logic [LENGTH_WIDTH-1:0] len_t;

    hunt_pos_t hunt_reg,      hunt_next;
    len_t      accum_reg,     accum_next;
    char_cnt_t seen_reg,      seen_next;
    logic      stopped_reg,   stopped_next;
    len_t      remain_reg,    remain_next;
    logic      out_valid_reg, out_valid_next;
    byte_t     data_reg,      data_next;
    logic      last_reg,      last_next;

    logic      accept;
    logic      emit;
    logic      is_digit;
    len_t      accum_upd;
    char_cnt_t seen_inc;

    // take a new word unless a held result cannot leave
    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    assign is_digit = (rx_byte inside {[CHAR_ZERO:CHAR_NINE]});
    assign seen_inc = seen_reg + 3'd1;

    // accum * 10 + digit as two shifts and adds
    assign accum_upd = {accum_reg[LENGTH_WIDTH-4:0], 3'b000}
                     + {accum_reg[LENGTH_WIDTH-2:0], 1'b0}
                     + LENGTH_WIDTH'(rx_byte[3:0]);

    // deframing state update
    always_comb
    begin
        hunt_next    = hunt_reg;
        accum_next   = accum_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        remain_next  = remain_reg;
        emit         = 1'b0;
        data_next    = rx_byte;
        last_next    = 1'b0;

        if (accept)
        begin
            if (passthrough)
            begin
                emit = 1'b1;
            end
            else if (remain_reg != '0)
            begin
                emit        = 1'b1;
                last_next   = (remain_reg == LENGTH_WIDTH'(1));
                remain_next = remain_reg - LENGTH_WIDTH'(1);
            end
            else if (hunt_reg < GATHER_POS)
            begin
                if (rx_byte == header_char(hunt_reg))
                begin
                    hunt_next = hunt_reg + 3'd1;
                    if (hunt_next == GATHER_POS)
                    begin
                        accum_next   = '0;
                        seen_next    = '0;
                        stopped_next = 1'b0;
                    end
                end
                else
                begin
                    hunt_next = '0;
                end
            end
            else if (rx_byte == CHAR_COLON)
            begin
                remain_next  = accum_reg;
                hunt_next    = '0;
                accum_next   = '0;
                seen_next    = '0;
                stopped_next = 1'b0;
            end
            else
            begin
                // atoi: digits only until the first non-digit
                if (!stopped_reg && is_digit)
                begin
                    accum_next = accum_upd;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
                seen_next = seen_inc;
                if (seen_inc >= 3'(LENGTH_CHARS_MAX))
                begin
                    remain_next  = accum_next;
                    hunt_next    = '0;
                    accum_next   = '0;
                    seen_next    = '0;
                    stopped_next = 1'b0;
                end
            end
        end
    end

    // result register
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg      <= '0;
            accum_reg     <= '0;
            seen_reg      <= '0;
            stopped_reg   <= 1'b0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            hunt_reg      <= hunt_next;
            accum_reg     <= accum_next;
            seen_reg      <= seen_next;
            stopped_reg   <= stopped_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload of the result word, loaded only on emit
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            data_reg <= data_next;
            last_reg <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign data_byte       = data_reg;
    assign last_of_payload = last_reg;

    // checks
    `IPD_ASSERT(a_payload_idle_hunt, (remain_reg != '0) |-> (hunt_reg == '0 && seen_reg == '0))
    `IPD_ASSERT_NEVER(a_seen_below_max, seen_reg >= 3'(LENGTH_CHARS_MAX))
    `IPD_ASSERT(a_stop_only_gather, stopped_reg |-> (hunt_reg == GATHER_POS))
    `IPD_ASSERT(a_last_flag, (accept && !passthrough && remain_reg == LENGTH_WIDTH'(1)) |=> (out_valid_reg && last_reg && remain_reg == '0))

endmodule
